/* hdl/dda_pkg.sv */
package dda_pkg;

  // Default configuration of the rasterizer
  localparam int COORD_BITS_DEF = 10;
  localparam int MAX_SPAN_DEF   = 63;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of the emitted pixel coordinates
  localparam int PIX_BITS = 10;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  // Classification of one line request
  typedef struct packed {
    logic too_long;
    logic zero_len;
    logic x_neg;
    logic y_neg;
  } line_cls_t;

  localparam int CLS_BITS = $bits(line_cls_t);

endpackage

/* hdl/dda_line_rasterizer.sv */
// DDA line rasterizer. Each request is one line given by its start and end pixel
// coordinates; the block answers with the start point and then one point per step
// along the major axis, every point rounded to the nearest pixel, and marks the final
// point with last_point. A zero-length line yields only its start point. A line whose
// major-axis span exceeds MAX_SPAN yields a single result with span_too_long and
// last_point set and zero coordinates. Increments carry FRAC_BITS fraction bits and
// come from a bit-serial divider, so a normal line of N steps occupies the back end for
// the divide and increment states (ST_DIV, ST_INC) followed by N + 1 output points;
// zero-length and too-long lines go straight to emit and skip the divider. Points
// leave at one per cycle while out_stall_i is low. A two-entry request queue sits
// between the classifier and the point generator, so up to two further lines are
// taken while a line is being drawn.
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_BITS-1:0]   x_pixel_o,
  output logic [PIX_BITS-1:0]   y_pixel_o,
  output logic                  last_point_o,
  output logic                  span_too_long_o
);

  localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
  localparam int ENTRY_W   = CLS_BITS + 2 * COORD_BITS + 3 * SPAN_BITS;

  line_cls_t             f_cls, q_cls;
  logic [SPAN_BITS-1:0]  f_steps, f_xmag, f_ymag;
  logic [SPAN_BITS-1:0]  q_steps, q_xmag, q_ymag;
  logic [COORD_BITS-1:0] q_xs, q_ys;
  logic                  q_push, q_full, q_pop, q_nonempty;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;

  // Classify incoming lines
  dda_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_SPAN   (MAX_SPAN),
    .SPAN_BITS  (SPAN_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .cls_o      (f_cls),
    .steps_o    (f_steps),
    .x_mag_o    (f_xmag),
    .y_mag_o    (f_ymag)
  );

  // Queue classified requests
  assign q_wdata = {f_cls, x_start_i, y_start_i, f_steps, f_xmag, f_ymag};
  assign {q_cls, q_xs, q_ys, q_steps, q_xmag, q_ymag} = q_rdata;

  dda_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .wdata_i    (q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .rdata_o    (q_rdata),
    .nonempty_o (q_nonempty)
  );

  // Divide and walk the line
  dda_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_SPAN   (MAX_SPAN),
    .FRAC_BITS  (FRAC_BITS),
    .SPAN_BITS  (SPAN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_nonempty),
    .cmd_pop_o       (q_pop),
    .cls_i           (q_cls),
    .x_start_i       (q_xs),
    .y_start_i       (q_ys),
    .steps_i         (q_steps),
    .x_mag_i         (q_xmag),
    .y_mag_i         (q_ymag),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x_pixel_o       (x_pixel_o),
    .y_pixel_o       (y_pixel_o),
    .last_point_o    (last_point_o),
    .span_too_long_o (span_too_long_o)
  );

  // A too-long line is a single, final, zeroed result
  a_too_long_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && span_too_long_o |-> last_point_o && x_pixel_o == '0 && y_pixel_o == '0)
    else $error("too-long result not final or not zeroed");

  // An accepted request is visible in the queue next cycle
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_nonempty)
    else $error("accepted request missing from queue");

  // The back end only pops a present entry
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");

endmodule

/* hdl/dda_front.sv */
module dda_front import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int SPAN_BITS  = $clog2(MAX_SPAN_DEF + 1)
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output line_cls_t             cls_o,
  output logic [SPAN_BITS-1:0]  steps_o,
  output logic [SPAN_BITS-1:0]  x_mag_o,
  output logic [SPAN_BITS-1:0]  y_mag_o
);

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]   dx_abs, dy_abs;
  logic [COORD_BITS-1:0] adx, ady, steps;

  // Form signed deltas and their magnitudes
  assign dx     = {1'b0, x_end_i} - {1'b0, x_start_i};
  assign dy     = {1'b0, y_end_i} - {1'b0, y_start_i};
  assign dx_abs = dx[COORD_BITS] ? ((COORD_BITS + 1)'(0) - dx) : dx;
  assign dy_abs = dy[COORD_BITS] ? ((COORD_BITS + 1)'(0) - dy) : dy;
  assign adx    = dx_abs[COORD_BITS-1:0];
  assign ady    = dy_abs[COORD_BITS-1:0];

  // Step count is the major-axis span
  assign steps = (adx > ady) ? adx : ady;

  // Classify the line
  always_comb begin
    cls_o.too_long = (32'(steps) > MAX_SPAN);
    cls_o.zero_len = (steps == '0);
    cls_o.x_neg    = dx[COORD_BITS];
    cls_o.y_neg    = dy[COORD_BITS];
  end

  assign steps_o = SPAN_BITS'(steps);
  assign x_mag_o = SPAN_BITS'(adx);
  assign y_mag_o = SPAN_BITS'(ady);

  // Accept a request whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

/* hdl/dda_fifo.sv */
module dda_fifo import dda_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             nonempty_o
);

  logic [WIDTH-1:0]   entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign rdata_o    = entry_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/dda_back.sv */
module dda_back import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SPAN_BITS  = $clog2(MAX_SPAN_DEF + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  line_cls_t             cls_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [SPAN_BITS-1:0]  steps_i,
  input  logic [SPAN_BITS-1:0]  x_mag_i,
  input  logic [SPAN_BITS-1:0]  y_mag_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_BITS-1:0]   x_pixel_o,
  output logic [PIX_BITS-1:0]   y_pixel_o,
  output logic                  last_point_o,
  output logic                  span_too_long_o
);

  localparam int POS_W = ((COORD_BITS + 1 > PIX_BITS) ? COORD_BITS + 1 : PIX_BITS) + FRAC_BITS;
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_INC  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

  logic [1:0]           state_q, state_d;
  logic                 out_valid_q;
  logic [SPAN_BITS-1:0] steps_q, k_q;
  logic [SPAN_BITS-1:0] x_rem_q, y_rem_q;
  logic [QUO_W-1:0]     x_quo_q, y_quo_q;
  logic                 x_neg_q, y_neg_q, too_long_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [POS_W-1:0]     x_pos_q, y_pos_q, x_inc_q, y_inc_q;
  logic [PIX_BITS-1:0]  x_pix_q, y_pix_q;
  logic                 last_q, flag_q;

  logic                 start_div, emit_go, is_last, x_full, y_full;
  logic [SPAN_BITS:0]   x_shift, y_shift, steps_ext;
  logic                 x_ge, y_ge;
  logic [SPAN_BITS-1:0] x_rem_next, y_rem_next;
  logic [POS_W-1:0]     x_round, y_round;

  // Pop a queued line when idle
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign start_div = !cls_i.too_long && !cls_i.zero_len;

  // One restoring-division step per cycle for both axes
  assign steps_ext  = {1'b0, steps_q};
  assign x_shift    = {x_rem_q, 1'b0};
  assign y_shift    = {y_rem_q, 1'b0};
  assign x_ge       = (x_shift >= steps_ext);
  assign y_ge       = (y_shift >= steps_ext);
  assign x_rem_next = x_ge ? SPAN_BITS'(x_shift - steps_ext) : SPAN_BITS'(x_shift);
  assign y_rem_next = y_ge ? SPAN_BITS'(y_shift - steps_ext) : SPAN_BITS'(y_shift);

  // Integer quotient bit: magnitude never exceeds the step count
  assign x_full = (x_mag_i == steps_i);
  assign y_full = (y_mag_i == steps_i);

  // Round the current position to the nearest pixel
  assign x_round = x_pos_q + HALF;
  assign y_round = y_pos_q + HALF;

  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign is_last = (k_q == steps_q);

  // Sequence divide and emit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = start_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_INC;
        end
      end
      ST_INC: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          x_pos_q    <= POS_W'(x_start_i) << FRAC_BITS;
          y_pos_q    <= POS_W'(y_start_i) << FRAC_BITS;
          steps_q    <= start_div ? steps_i : '0;
          k_q        <= '0;
          too_long_q <= cls_i.too_long;
          x_neg_q    <= cls_i.x_neg;
          y_neg_q    <= cls_i.y_neg;
          x_quo_q    <= QUO_W'(x_full);
          y_quo_q    <= QUO_W'(y_full);
          x_rem_q    <= x_full ? '0 : x_mag_i;
          y_rem_q    <= y_full ? '0 : y_mag_i;
          cnt_q      <= CNT_W'(FRAC_BITS);
        end
      end
      ST_DIV: begin
        x_rem_q <= x_rem_next;
        y_rem_q <= y_rem_next;
        x_quo_q <= {x_quo_q[QUO_W-2:0], x_ge};
        y_quo_q <= {y_quo_q[QUO_W-2:0], y_ge};
        cnt_q   <= cnt_q - 1'b1;
      end
      ST_INC: begin
        x_inc_q <= x_neg_q ? (POS_W'(0) - POS_W'(x_quo_q)) : POS_W'(x_quo_q);
        y_inc_q <= y_neg_q ? (POS_W'(0) - POS_W'(y_quo_q)) : POS_W'(y_quo_q);
      end
      ST_EMIT: begin
        if (emit_go) begin
          x_pix_q <= too_long_q ? '0 : x_round[FRAC_BITS +: PIX_BITS];
          y_pix_q <= too_long_q ? '0 : y_round[FRAC_BITS +: PIX_BITS];
          last_q  <= is_last;
          flag_q  <= too_long_q;
          x_pos_q <= x_pos_q + x_inc_q;
          y_pos_q <= y_pos_q + y_inc_q;
          k_q     <= k_q + 1'b1;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign x_pixel_o       = x_pix_q;
  assign y_pixel_o       = y_pix_q;
  assign last_point_o    = last_q;
  assign span_too_long_o = flag_q;

endmodule
